[src/occupancy_grid_owner_map_macros.svh]
// ----------------------------------------------------------------------------
// Occupancy grid owner map: assertion macros
// Clocked on clk, disabled while arst_n is low. Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_OWNER_MAP_MACROS_SVH
`define OCCUPANCY_GRID_OWNER_MAP_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define OGOM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// expression must never be true at a clock edge out of reset
`define OGOM_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define OGOM_ASSERT(lbl, prop, msg)
`define OGOM_NEVER(lbl, expr, msg)
`endif

`endif

[src/ogom_pkg.sv]
// ----------------------------------------------------------------------------
// ogom_pkg
// Shared field widths, action and register codes, and control structs of the
// occupancy grid owner map.
// ----------------------------------------------------------------------------
`default_nettype none

package ogom_pkg;

	// field widths fixed by the interface
	localparam int DIM_W     = 9;
	localparam int PROD_W    = 2 * DIM_W;
	localparam int SIZE_W    = 4;
	localparam int COORD_W   = 8;
	localparam int END_W     = 9;
	localparam int MASK_W    = 64;
	localparam int BIT_W     = 6;
	localparam int IDX_W     = 16;
	localparam int OWN_IO_W  = 12;
	localparam int COUNT_W   = 17;
	localparam int REG_IDX_W = 2;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

	localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

	typedef enum logic [2:0] {
		ACT_ADD    = 3'd0,
		ACT_MADD   = 3'd1,
		ACT_REMOVE = 3'd2,
		ACT_QUERY  = 3'd3,
		ACT_CLEAN  = 3'd4
	} action_t;

	// controller to cell walker
	typedef struct packed {
		logic start;
		logic step;
	} walk_ctrl_t;

	// per-cell flags traveling with a read request into the update stage
	typedef struct packed {
		logic vld;
		logic mbit;
	} cell_flags_t;

endpackage

`default_nettype wire

[src/ogom_ram.sv]
// ----------------------------------------------------------------------------
// ogom_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ogom_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[src/ogom_walk.sv]
// ----------------------------------------------------------------------------
// ogom_walk
// Cell walker: steps through the cells of one request (rectangle, whole grid
// or a single index), issues one memory read per cycle and carries the cell
// address and flags into the update stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ogom_walk import ogom_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  walk_ctrl_t           ctrl,
	input  action_t              op,
	input  logic [COORD_W-1:0]   cx,
	input  logic [COORD_W-1:0]   cz,
	input  logic [SIZE_W-1:0]    sx,
	input  logic [SIZE_W-1:0]    sz,
	input  logic [DIM_W-1:0]     w,
	input  logic [DIM_W-1:0]     h,
	input  logic [ADDR_BITS:0]   total,
	input  logic [IDX_W-1:0]     idx,
	input  logic [MASK_W-1:0]    mask,
	output logic                 rd_en,
	output logic [ADDR_BITS-1:0] rd_addr,
	output logic                 last,
	output cell_flags_t          flags_s1,
	output logic [ADDR_BITS-1:0] addr_s1
);

	localparam int CMP_W = (ADDR_BITS + 1 > IDX_W) ? ADDR_BITS + 1 : IDX_W;

	logic [SIZE_W-1:0]    x_q;
	logic [SIZE_W-1:0]    z_q;
	logic [BIT_W-1:0]     bit_q;
	logic [ADDR_BITS-1:0] i_q;

	logic [DIM_W-1:0]  col;
	logic [DIM_W-1:0]  row;
	logic [PROD_W-1:0] row_base;
	logic [PROD_W-1:0] rect_lin;
	logic              rect_in;
	logic              rect_last;
	logic              x_end;
	logic              cell_vld;

	// rectangle cell position; mask bit index equals the loop position
	assign col       = DIM_W'(cx) + DIM_W'(x_q);
	assign row       = DIM_W'(cz) + DIM_W'(z_q);
	assign row_base  = PROD_W'(row) * PROD_W'(w);
	assign rect_lin  = row_base + PROD_W'(col);
	assign rect_in   = (col < w) && (row < h) && (sx != '0) && (sz != '0);
	assign x_end     = (x_q == sx - SIZE_W'(1));
	assign rect_last = (sx == '0) || (sz == '0) || (x_end && (z_q == sz - SIZE_W'(1)));

	// current cell by action
	always_comb begin
		cell_vld = 1'b0;
		rd_addr  = '0;
		last     = 1'b1;
		case (op)
			ACT_ADD, ACT_MADD, ACT_REMOVE: begin
				cell_vld = rect_in;
				rd_addr  = ADDR_BITS'(rect_lin);
				last     = rect_last;
			end
			ACT_QUERY: begin
				cell_vld = CMP_W'(idx) < CMP_W'(total);
				rd_addr  = ADDR_BITS'(idx);
				last     = 1'b1;
			end
			ACT_CLEAN: begin
				cell_vld = 1'b1;
				rd_addr  = i_q;
				last     = ((ADDR_BITS + 1)'(i_q) + (ADDR_BITS + 1)'(1)) == total;
			end
			default: begin
				cell_vld = 1'b0;
				rd_addr  = '0;
				last     = 1'b1;
			end
		endcase
	end

	assign rd_en = ctrl.step && cell_vld;

	// loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			z_q      <= '0;
			bit_q    <= '0;
			i_q      <= '0;
			flags_s1 <= '0;
		end else begin
			if (ctrl.start) begin
				x_q   <= '0;
				z_q   <= '0;
				bit_q <= '0;
				i_q   <= '0;
			end else if (ctrl.step) begin
				if (x_end) begin
					x_q <= '0;
					z_q <= z_q + SIZE_W'(1);
				end else begin
					x_q <= x_q + SIZE_W'(1);
				end
				bit_q <= bit_q + BIT_W'(1);
				i_q   <= i_q + ADDR_BITS'(1);
			end
			flags_s1.vld  <= ctrl.step && cell_vld;
			flags_s1.mbit <= mask[bit_q];
		end
	end

	// cell address travels with the read
	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
	end

endmodule

`default_nettype wire

[src/ogom_upd.sv]
// ----------------------------------------------------------------------------
// ogom_upd
// Update stage: takes the read data of one cell, decides the write back for
// the action and keeps the query answer and the cleared-cell count.
// ----------------------------------------------------------------------------
`default_nettype none

module ogom_upd import ogom_pkg::*; #(
	parameter int OWNER_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  action_t               op,
	input  logic [OWNER_BITS-1:0] own,
	input  cell_flags_t           flags_s1,
	input  logic [OWNER_BITS-1:0] rd_data,
	output logic                  we,
	output logic [OWNER_BITS-1:0] wdata,
	output logic [COUNT_W-1:0]    count,
	output logic [OWNER_BITS-1:0] found
);

	logic own_hit;
	logic is_free;

	assign own_hit = (rd_data == own);
	assign is_free = (rd_data == '0);

	// write back decision
	always_comb begin
		we    = 1'b0;
		wdata = '0;
		case (op)
			ACT_ADD: begin
				we    = flags_s1.vld;
				wdata = own;
			end
			ACT_MADD: begin
				we    = flags_s1.vld && is_free && flags_s1.mbit;
				wdata = own;
			end
			ACT_REMOVE, ACT_CLEAN: begin
				we    = flags_s1.vld && own_hit;
				wdata = '0;
			end
			default: begin
				we    = 1'b0;
				wdata = '0;
			end
		endcase
	end

	// query answer and clean count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count <= '0;
			found <= '0;
		end else if (start) begin
			count <= '0;
			found <= '0;
		end else if (flags_s1.vld) begin
			if (op == ACT_CLEAN && own_hit) begin
				count <= count + COUNT_W'(1);
			end
			if (op == ACT_QUERY) begin
				found <= rd_data;
			end
		end
	end

endmodule

`default_nettype wire

[src/occupancy_grid_owner_map.sv]
// Rectangle request: the walker steps through sx*sz cells (at least one, at most
// 64) between the setup state and the wait and finish states; query: one cell.
// Clean: all W*H cells. One cell per cycle, set by the single read/write port
// pair of the grid RAM and its registered read.
// Reset: the grid is swept to zero, all GRID_SIDE*GRID_SIDE cells (65536 by
// default); no request is taken during the sweep, config writes are.
// ----------------------------------------------------------------------------
// occupancy_grid_owner_map
// Grid of owner ids held in one RAM; add, masked add, remove, query and clean
// requests walk their cells with a read-modify-write pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
`include "occupancy_grid_owner_map_macros.svh"

module occupancy_grid_owner_map import ogom_pkg::*; #(
	parameter int GRID_SIDE     = 256,
	parameter int MAX_FOOTPRINT = 8,
	parameter int OWNER_BITS    = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           action,
	input  logic [OWN_IO_W-1:0]  owner,
	input  logic [COORD_W-1:0]   corner_x,
	input  logic [COORD_W-1:0]   corner_z,
	input  logic [SIZE_W-1:0]    size_x,
	input  logic [SIZE_W-1:0]    size_z,
	input  logic [MASK_W-1:0]    yard_mask,
	input  logic                 immobile,
	input  logic [IDX_W-1:0]     cell_index,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OWN_IO_W-1:0]  owner_found,
	output logic                 terrain_changed,
	output logic [COORD_W-1:0]   change_x0,
	output logic [COORD_W-1:0]   change_z0,
	output logic [END_W-1:0]     change_x1,
	output logic [END_W-1:0]     change_z1,
	output logic [COUNT_W-1:0]   cleared_count,
	// configuration channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	localparam int CELLS     = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_BITS = $clog2(CELLS);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_SETUP = 6'b000100,
		ST_RUN   = 6'b001000,
		ST_WAIT  = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q;

	logic [DIM_W-1:0]      width_q;
	logic [DIM_W-1:0]      height_q;
	logic [ADDR_BITS-1:0]  clr_q;

	// captured request
	action_t               act_q;
	logic [OWNER_BITS-1:0] own_q;
	logic [COORD_W-1:0]    cx_q;
	logic [COORD_W-1:0]    cz_q;
	logic [SIZE_W-1:0]     sx_q;
	logic [SIZE_W-1:0]     sz_q;
	logic [MASK_W-1:0]     mask_q;
	logic                  imm_q;
	logic [IDX_W-1:0]      idx_q;
	logic [DIM_W-1:0]      w_q;
	logic [DIM_W-1:0]      h_q;
	logic [ADDR_BITS:0]    total_q;

	logic [DIM_W-1:0]      w_eff;
	logic [DIM_W-1:0]      h_eff;
	logic [SIZE_W-1:0]     sx_sat;
	logic [SIZE_W-1:0]     sz_sat;
	logic [PROD_W-1:0]     area;
	logic                  in_acc;
	logic                  out_free;
	logic                  clearing;
	logic                  changed;

	walk_ctrl_t            walk_ctrl;
	cell_flags_t           flags_s1;
	logic [ADDR_BITS-1:0]  addr_s1;
	logic                  rd_en;
	logic [ADDR_BITS-1:0]  rd_addr;
	logic                  walk_last;
	logic [OWNER_BITS-1:0] rd_data;
	logic                  upd_we;
	logic [OWNER_BITS-1:0] upd_wdata;
	logic [COUNT_W-1:0]    count;
	logic [OWNER_BITS-1:0] found;
	logic                  ram_we;
	logic [ADDR_BITS-1:0]  ram_waddr;
	logic [OWNER_BITS-1:0] ram_wdata;

	// clamps of grid dimensions and rectangle sizes
	assign w_eff  = (width_q == '0) ? DIM_W'(1) :
		(32'(width_q) > GRID_SIDE) ? DIM_W'(GRID_SIDE) : width_q;
	assign h_eff  = (height_q == '0) ? DIM_W'(1) :
		(32'(height_q) > GRID_SIDE) ? DIM_W'(GRID_SIDE) : height_q;
	assign sx_sat = (32'(size_x) > MAX_FOOTPRINT) ? SIZE_W'(MAX_FOOTPRINT) : size_x;
	assign sz_sat = (32'(size_z) > MAX_FOOTPRINT) ? SIZE_W'(MAX_FOOTPRINT) : size_z;
	assign area   = PROD_W'(w_q) * PROD_W'(h_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || out_ready;
	assign clearing  = (state_q == ST_CLEAR);
	assign changed   = (act_q inside {ACT_ADD, ACT_MADD, ACT_REMOVE}) && imm_q;

	assign walk_ctrl.start = (state_q == ST_SETUP);
	assign walk_ctrl.step  = (state_q == ST_RUN);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_WIDTH:  width_q  <= cfg_data;
				REG_GRID_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			// result valid: raised when the answer is loaded, dropped once taken
			if (state_q == ST_FIN && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_BITS'(1);
					if (clr_q == ADDR_BITS'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (act_q inside {ACT_ADD, ACT_MADD, ACT_REMOVE, ACT_QUERY, ACT_CLEAN}) begin
						state_q <= ST_RUN;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_RUN: begin
					if (walk_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture and result register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q  <= action_t'(action);
			own_q  <= OWNER_BITS'(owner);
			cx_q   <= corner_x;
			cz_q   <= corner_z;
			sx_q   <= sx_sat;
			sz_q   <= sz_sat;
			mask_q <= yard_mask;
			imm_q  <= immobile;
			idx_q  <= cell_index;
			w_q    <= w_eff;
			h_q    <= h_eff;
		end
		if (state_q == ST_SETUP) begin
			total_q <= (ADDR_BITS + 1)'(area);
		end
		if (state_q == ST_FIN && out_free) begin
			owner_found     <= OWN_IO_W'(found);
			terrain_changed <= changed;
			change_x0       <= changed ? cx_q : '0;
			change_z0       <= changed ? cz_q : '0;
			change_x1       <= changed ? END_W'(cx_q) + END_W'(sx_q) : '0;
			change_z1       <= changed ? END_W'(cz_q) + END_W'(sz_q) : '0;
			cleared_count   <= count;
		end
	end

	ogom_walk #(
		.ADDR_BITS(ADDR_BITS)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (walk_ctrl),
		.op       (act_q),
		.cx       (cx_q),
		.cz       (cz_q),
		.sx       (sx_q),
		.sz       (sz_q),
		.w        (w_q),
		.h        (h_q),
		.total    (total_q),
		.idx      (idx_q),
		.mask     (mask_q),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.last     (walk_last),
		.flags_s1 (flags_s1),
		.addr_s1  (addr_s1)
	);

	ogom_upd #(
		.OWNER_BITS(OWNER_BITS)
	) u_upd (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (walk_ctrl.start),
		.op       (act_q),
		.own      (own_q),
		.flags_s1 (flags_s1),
		.rd_data  (rd_data),
		.we       (upd_we),
		.wdata    (upd_wdata),
		.count    (count),
		.found    (found)
	);

	// write port: reset sweep or write back
	assign ram_we    = clearing || upd_we;
	assign ram_waddr = clearing ? clr_q : addr_s1;
	assign ram_wdata = clearing ? '0 : upd_wdata;

	ogom_ram #(
		.WIDTH(OWNER_BITS),
		.DEPTH(CELLS)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// checks
	`OGOM_NEVER(a_idle_no_write, (state_q == ST_IDLE) && ram_we, "grid written while idle")
	`OGOM_ASSERT(a_s1_from_run, flags_s1.vld |-> $past(state_q == ST_RUN), "stray cell in update stage")
	`OGOM_NEVER(a_rw_collide, ram_we && rd_en && (ram_waddr == rd_addr), "read and write hit one cell")
	`OGOM_NEVER(a_read_in_clear, clearing && rd_en, "grid read during reset sweep")

endmodule

`default_nettype wire

[tb/ogom_checker.sv]
// ----------------------------------------------------------------------------
// ogom_checker
// Watches the request, result and register channels of the occupancy grid
// owner map, keeps its own copy of the grid and the grid size, works out the
// answer to each accepted request and compares each accepted result with the
// oldest answer still waiting.
// ----------------------------------------------------------------------------
module ogom_checker import ogom_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [2:0]           action,
	input  logic [OWN_IO_W-1:0]  owner,
	input  logic [COORD_W-1:0]   corner_x,
	input  logic [COORD_W-1:0]   corner_z,
	input  logic [SIZE_W-1:0]    size_x,
	input  logic [SIZE_W-1:0]    size_z,
	input  logic [MASK_W-1:0]    yard_mask,
	input  logic                 immobile,
	input  logic [IDX_W-1:0]     cell_index,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [OWN_IO_W-1:0]  owner_found,
	input  logic                 terrain_changed,
	input  logic [COORD_W-1:0]   change_x0,
	input  logic [COORD_W-1:0]   change_z0,
	input  logic [END_W-1:0]     change_x1,
	input  logic [END_W-1:0]     change_z1,
	input  logic [COUNT_W-1:0]   cleared_count,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	output int unsigned          pending,
	output int unsigned          mismatches
);

	localparam int CELL_COUNT = 65536;
	localparam int SIDE_MAX   = 256;
	localparam int FOOT_MAX   = 8;
	localparam int PRINT_CAP  = 100;

	typedef struct {
		logic [OWN_IO_W-1:0] owner_found;
		logic                terrain_changed;
		logic [COORD_W-1:0]  x0;
		logic [COORD_W-1:0]  z0;
		logic [END_W-1:0]    x1;
		logic [END_W-1:0]    z1;
		logic [COUNT_W-1:0]  cleared;
	} grid_answer_t;

	// local copy of the grid, the size registers and the answers in flight
	logic [OWN_IO_W-1:0] cell_owner [0:CELL_COUNT-1];
	logic [DIM_W-1:0]    width_reg;
	logic [DIM_W-1:0]    height_reg;
	grid_answer_t        grid_answers [$];

	// register value to the size actually used: 0 acts as 1, above 256 as 256
	function automatic int unsigned effective_span(logic [DIM_W-1:0] raw);
		if (raw == '0)
			return 1;
		if (raw > SIDE_MAX)
			return SIDE_MAX;
		return raw;
	endfunction

	// applies one request to the local grid and returns the result it must give
	function automatic grid_answer_t predict_grid_answer(
		logic [2:0] act, logic [OWN_IO_W-1:0] who,
		logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cz,
		logic [SIZE_W-1:0] szx, logic [SIZE_W-1:0] szz,
		logic [MASK_W-1:0] mask, logic fixed, logic [IDX_W-1:0] idx);
		grid_answer_t ans;
		int unsigned w, h, sx, sz, row, col, lin, count;
		ans = '{default: '0};
		w = effective_span(width_reg);
		h = effective_span(height_reg);
		sx = (szx > FOOT_MAX) ? FOOT_MAX : szx;
		sz = (szz > FOOT_MAX) ? FOOT_MAX : szz;
		count = 0;
		case (act)
		ACT_ADD, ACT_MADD, ACT_REMOVE: begin
			for (int dz = 0; dz < sz; dz++) begin
				row = cz + dz;
				if (row >= h)
					continue;
				for (int dx = 0; dx < sx; dx++) begin
					col = cx + dx;
					// off-grid cells are skipped, never wrapped
					if (col >= w)
						continue;
					lin = col + row * w;
					if (act == ACT_ADD) begin
						cell_owner[lin] = who;
					end else if (act == ACT_MADD) begin
						if (cell_owner[lin] == '0 && mask[(dx + dz * sx) % 64])
							cell_owner[lin] = who;
					end else if (cell_owner[lin] == who) begin
						cell_owner[lin] = '0;
					end
				end
			end
			// reported rectangle is the saturated one, not clipped to the grid
			ans.terrain_changed = fixed;
			if (fixed) begin
				ans.x0 = cx;
				ans.z0 = cz;
				ans.x1 = END_W'(cx + sx);
				ans.z1 = END_W'(cz + sz);
			end
		end
		ACT_QUERY: begin
			if (idx < w * h)
				ans.owner_found = cell_owner[idx];
		end
		ACT_CLEAN: begin
			for (int i = 0; i < w * h; i++) begin
				if (cell_owner[i] == who) begin
					cell_owner[i] = '0;
					count++;
				end
			end
			ans.cleared = COUNT_W'(count);
		end
		default: begin
			// unknown codes leave the grid alone and answer zeros
		end
		endcase
		return ans;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		if (mismatches < PRINT_CAP)
			$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic compare_answer(grid_answer_t got, grid_answer_t want);
		if (got.owner_found !== want.owner_found)
			report_mismatch("owner_found", got.owner_found, want.owner_found);
		if (got.terrain_changed !== want.terrain_changed)
			report_mismatch("terrain_changed", got.terrain_changed, want.terrain_changed);
		if (got.x0 !== want.x0)
			report_mismatch("change_x0", got.x0, want.x0);
		if (got.z0 !== want.z0)
			report_mismatch("change_z0", got.z0, want.z0);
		if (got.x1 !== want.x1)
			report_mismatch("change_x1", got.x1, want.x1);
		if (got.z1 !== want.z1)
			report_mismatch("change_z1", got.z1, want.z1);
		if (got.cleared !== want.cleared)
			report_mismatch("cleared_count", got.cleared, want.cleared);
	endtask

	// results are checked before new requests are predicted: a result can
	// never belong to a request accepted at the same edge
	always @(posedge clk) begin
		grid_answer_t seen;
		if (!arst_n) begin
			width_reg = DIM_RESET;
			height_reg = DIM_RESET;
			grid_answers.delete();
			foreach (cell_owner[i])
				cell_owner[i] = '0;
		end else begin
			if (out_valid && out_ready) begin
				seen = '{owner_found, terrain_changed, change_x0, change_z0,
					change_x1, change_z1, cleared_count};
				if (grid_answers.size() == 0)
					report_mismatch("result with no request waiting", 0, 0);
				else
					compare_answer(seen, grid_answers.pop_front());
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_GRID_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == REG_GRID_HEIGHT)
					height_reg = cfg_data;
			end
			if (in_valid && in_ready)
				grid_answers.push_back(predict_grid_answer(action, owner, corner_x,
					corner_z, size_x, size_z, yard_mask, immobile, cell_index));
		end
		pending = grid_answers.size();
	end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the occupancy grid owner map: a directed pass over
// field extremes and corner cases, then random phases at several grid sizes
// with random idling on both channels. Checking is done by ogom_checker.
// ----------------------------------------------------------------------------
module testbench import ogom_pkg::*;;

	localparam int          CYCLE_LIMIT  = 3_000_000;
	localparam int          TAIL_CYCLES  = 200;
	localparam int          IDLE_PERCENT = 38;
	localparam int          POOL_SIZE    = 6;
	localparam int          BIG_GRID     = 4096;
	// action codes the block does not define
	localparam logic [2:0]  ACT_VOID_LO  = 3'd5;
	localparam logic [2:0]  ACT_VOID_HI  = 3'd7;

	typedef struct {
		logic [2:0]          act;
		logic [OWN_IO_W-1:0] who;
		logic [COORD_W-1:0]  cx;
		logic [COORD_W-1:0]  cz;
		logic [SIZE_W-1:0]   sx;
		logic [SIZE_W-1:0]   sz;
		logic [MASK_W-1:0]   mask;
		logic                fixed;
		logic [IDX_W-1:0]    idx;
	} grid_request_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [2:0]           action;
	logic [OWN_IO_W-1:0]  owner;
	logic [COORD_W-1:0]   corner_x;
	logic [COORD_W-1:0]   corner_z;
	logic [SIZE_W-1:0]    size_x;
	logic [SIZE_W-1:0]    size_z;
	logic [MASK_W-1:0]    yard_mask;
	logic                 immobile;
	logic [IDX_W-1:0]     cell_index;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [OWN_IO_W-1:0]  owner_found;
	logic                 terrain_changed;
	logic [COORD_W-1:0]   change_x0;
	logic [COORD_W-1:0]   change_z0;
	logic [END_W-1:0]     change_x1;
	logic [END_W-1:0]     change_z1;
	logic [COUNT_W-1:0]   cleared_count;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	int unsigned          pending;
	int unsigned          mismatches;

	// stimulus state
	logic                 steady = 1'b0;
	int unsigned          eff_w;
	int unsigned          eff_h;
	int unsigned          big_cleans_left;
	logic [OWN_IO_W-1:0]  owner_pool [POOL_SIZE];
	int unsigned          cycle_count = 0;

	occupancy_grid_owner_map dut (.*);
	ogom_checker checker_i (.*);

	always #6 clk = ~clk;

	// result side back-pressure
	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	// runaway guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic grid_request_t make_request(logic [2:0] act, logic [OWN_IO_W-1:0] who,
		logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cz, logic [SIZE_W-1:0] sx,
		logic [SIZE_W-1:0] sz, logic [MASK_W-1:0] mask, logic fixed, logic [IDX_W-1:0] idx);
		grid_request_t r;
		r = '{act, who, cx, cz, sx, sz, mask, fixed, idx};
		return r;
	endfunction

	// mostly legal footprints, some empty and some above the saturation bound
	function automatic logic [SIZE_W-1:0] random_size();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return '0;
		if (pick < 18)
			return SIZE_W'($urandom_range(9, 15));
		return SIZE_W'($urandom_range(1, 8));
	endfunction

	function automatic grid_request_t random_request();
		grid_request_t r;
		int unsigned pick, cells, reach_x, reach_z, reach_i;
		cells = eff_w * eff_h;
		reach_x = (eff_w + 2 > 255) ? 255 : eff_w + 2;
		reach_z = (eff_h + 2 > 255) ? 255 : eff_h + 2;
		reach_i = (cells + 3 > 65535) ? 65535 : cells + 3;
		// owners mostly from a small pool so removes and cleans find matches
		r.who = owner_pool[$urandom_range(0, POOL_SIZE - 1)];
		if ($urandom_range(0, 19) == 0)
			r.who = OWN_IO_W'($urandom_range(0, 4095));
		r.cx = COORD_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) :
			$urandom_range(0, reach_x));
		r.cz = COORD_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) :
			$urandom_range(0, reach_z));
		r.sx = random_size();
		r.sz = random_size();
		r.mask = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0)
			r.mask = '1;
		r.fixed = 1'($urandom_range(0, 1));
		r.idx = IDX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
			$urandom_range(0, reach_i));
		pick = $urandom_range(0, 99);
		if (pick < 26)
			r.act = ACT_ADD;
		else if (pick < 46)
			r.act = ACT_MADD;
		else if (pick < 66)
			r.act = ACT_REMOVE;
		else if (pick < 90)
			r.act = ACT_QUERY;
		else if (pick < 97)
			r.act = ACT_CLEAN;
		else
			r.act = 3'($urandom_range(ACT_VOID_LO, ACT_VOID_HI));
		// a clean walks the whole grid: keep them rare on big grids
		if (r.act == ACT_CLEAN && cells > BIG_GRID) begin
			if (big_cleans_left == 0)
				r.act = ACT_QUERY;
			else
				big_cleans_left--;
		end
		return r;
	endfunction

	// one request with a random hold-off in front; returns at the accepting edge
	task automatic issue_request(grid_request_t r);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= r.act;
		owner <= r.who;
		corner_x <= r.cx;
		corner_z <= r.cz;
		size_x <= r.sx;
		size_z <= r.sz;
		yard_mask <= r.mask;
		immobile <= r.fixed;
		cell_index <= r.idx;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop requesting and wait for every answer to come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic set_grid(logic [DIM_W-1:0] raw_w, logic [DIM_W-1:0] raw_h);
		drain();
		write_register(REG_GRID_WIDTH, raw_w);
		write_register(REG_GRID_HEIGHT, raw_h);
		eff_w = (raw_w == 0) ? 1 : (raw_w > 256) ? 256 : raw_w;
		eff_h = (raw_h == 0) ? 1 : (raw_h > 256) ? 256 : raw_h;
	endtask

	task automatic run_phase(logic [DIM_W-1:0] raw_w, logic [DIM_W-1:0] raw_h,
		int unsigned count, logic quiet);
		set_grid(raw_w, raw_h);
		steady = quiet;
		big_cleans_left = 1;
		foreach (owner_pool[i])
			owner_pool[i] = OWN_IO_W'($urandom_range(1, 4095));
		repeat (count)
			issue_request(random_request());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_QUERY;
		owner = '0;
		corner_x = '0;
		corner_z = '0;
		size_x = '0;
		size_z = '0;
		yard_mask = '0;
		immobile = 1'b0;
		cell_index = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_GRID_WIDTH;
		cfg_data = '0;
		eff_w = 256;
		eff_h = 256;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed part on the reset-size grid
		// clean of owner zero on a fresh grid counts every cell
		issue_request(make_request(ACT_CLEAN, 12'h000, 8'h00, 8'h00, 4'h0, 4'h0, '0, 1'b0, 16'h0));
		issue_request(make_request(ACT_ADD, 12'hFFF, 8'h00, 8'h00, 4'h8, 4'h8, '0, 1'b1, 16'h0));
		issue_request(make_request(ACT_QUERY, 12'h000, 8'h00, 8'h00, 4'h0, 4'h0, '0, 1'b0, 16'h0));
		issue_request(make_request(ACT_QUERY, 12'h000, 8'h00, 8'h00, 4'h0, 4'h0, '0, 1'b0, 16'hFFFF));
		// far corner, oversized footprint mostly off the grid
		issue_request(make_request(ACT_ADD, 12'h001, 8'hFF, 8'hFF, 4'hF, 4'hF, '0, 1'b1, 16'h0));
		issue_request(make_request(ACT_QUERY, 12'h000, 8'h00, 8'h00, 4'h0, 4'h0, '0, 1'b0, 16'hFFFF));
		// masked add overlapping an occupied block
		issue_request(make_request(ACT_MADD, 12'h555, 8'h04, 8'h04, 4'h8, 4'h8,
			64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 16'h0));
		// empty footprint still reports the change
		issue_request(make_request(ACT_MADD, 12'hAAA, 8'h0A, 8'h0A, 4'h0, 4'h3, '1, 1'b1, 16'h0));
		issue_request(make_request(ACT_REMOVE, 12'hAAA, 8'h00, 8'h00, 4'h8, 4'h8, '0, 1'b0, 16'h0));
		issue_request(make_request(ACT_REMOVE, 12'hFFF, 8'h02, 8'h02, 4'h4, 4'h4, '0, 1'b1, 16'h0));
		// owner zero on add, query, masked add and remove
		issue_request(make_request(ACT_ADD, 12'h000, 8'h00, 8'h00, 4'h1, 4'h1, '0, 1'b0, 16'h0));
		issue_request(make_request(ACT_QUERY, 12'h000, 8'h00, 8'h00, 4'h0, 4'h0, '0, 1'b0, 16'h1));
		issue_request(make_request(ACT_MADD, 12'h000, 8'h64, 8'h64, 4'h8, 4'h8, '1, 1'b0, 16'h0));
		issue_request(make_request(ACT_REMOVE, 12'h000, 8'h00, 8'h00, 4'h8, 4'h8, '0, 1'b1, 16'h0));
		issue_request(make_request(ACT_VOID_LO, 12'h123, 8'h01, 8'h01, 4'h2, 4'h2, '1, 1'b1, 16'h5));
		issue_request(make_request(ACT_VOID_HI, 12'hFFF, 8'hFF, 8'hFF, 4'hF, 4'hF, '1, 1'b1, 16'hFFFF));
		issue_request(make_request(ACT_QUERY, 12'h000, 8'h00, 8'h00, 4'h0, 4'h0, '0, 1'b0, 16'd1029));
		issue_request(make_request(ACT_CLEAN, 12'hFFF, 8'h00, 8'h00, 4'h0, 4'h0, '0, 1'b0, 16'h0));

		// tiny grid: clipping and out-of-range query
		set_grid(9'd3, 9'd5);
		issue_request(make_request(ACT_ADD, 12'h007, 8'h02, 8'h04, 4'h2, 4'h2, '0, 1'b1, 16'h0));
		issue_request(make_request(ACT_QUERY, 12'h000, 8'h00, 8'h00, 4'h0, 4'h0, '0, 1'b0, 16'd14));
		issue_request(make_request(ACT_QUERY, 12'h000, 8'h00, 8'h00, 4'h0, 4'h0, '0, 1'b0, 16'd15));
		issue_request(make_request(ACT_CLEAN, 12'h000, 8'h00, 8'h00, 4'h0, 4'h0, '0, 1'b0, 16'h0));
		issue_request(make_request(ACT_QUERY, 12'h000, 8'h00, 8'h00, 4'h0, 4'h0, '0, 1'b0, 16'hFFFF));

		// random phases over a spread of grid sizes, register extremes included
		run_phase(9'd16, 9'd16, 220, 1'b0);
		run_phase(9'd0, 9'd511, 180, 1'b0);
		run_phase(9'd511, 9'd0, 180, 1'b0);
		run_phase(9'd24, 9'd40, 220, 1'b1);
		run_phase(9'd300, 9'd9, 180, 1'b0);
		run_phase(9'd37, 9'd200, 200, 1'b0);
		run_phase(9'd1, 9'd1, 120, 1'b0);
		run_phase(9'd256, 9'd256, 260, 1'b0);
		run_phase(9'd7, 9'd130, 240, 1'b0);

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/ogom_pkg.sv
src/ogom_ram.sv
src/ogom_walk.sv
src/ogom_upd.sv
src/occupancy_grid_owner_map.sv
tb/ogom_checker.sv
tb/testbench.sv
